@@ rtl/core/rldp_pkg.sv @@
// ----------------------------------------------------------------------------
// rldp_pkg
// Shared constants and types for the raster line dither and pack block.
// ----------------------------------------------------------------------------
package rldp_pkg;

  localparam int MATRIX_SIDE = 16;
  localparam int SIDE_W = $clog2(MATRIX_SIDE);
  localparam int TBL_AW = 2 * SIDE_W;
  localparam int TBL_DEPTH = MATRIX_SIDE * MATRIX_SIDE;

  localparam int LINE_BYTES_MAX_DEF = 4096;
  localparam int ITEM_Q_DEPTH_DEF = 4;
  localparam int RES_Q_DEPTH_DEF = 2;

  localparam int COORD_W = 15;
  localparam int IDX_W = 12;
  localparam int LS_W = 13;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [7:0] DOT_MSB = 8'h80;
  localparam logic [2:0] LAST_BIT = 3'd7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [2:0] REG_WINDOW_LEFT = 3'd0;
  localparam logic [2:0] REG_WINDOW_RIGHT = 3'd1;
  localparam logic [2:0] REG_WINDOW_TOP = 3'd2;
  localparam logic [2:0] REG_WINDOW_BOTTOM = 3'd3;
  localparam logic [2:0] REG_ONE_BIT_MODE = 3'd4;
  localparam logic [2:0] REG_BLACK_SPACE = 3'd5;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [7:0]         value;
    logic               line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] byte_index;
    logic             line_last;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] window_left;
    logic [COORD_W-1:0] window_right;
    logic [COORD_W-1:0] window_top;
    logic [COORD_W-1:0] window_bottom;
    logic               one_bit_mode;
    logic               black_space;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_PIX,
    KIND_BYTE,
    KIND_PASS
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [TBL_AW-1:0] tbl_addr;
    logic [7:0]        value;
    logic              line_end;
    logic              edge_col;
    logic              k_ok;
    logic              need_prev;
    logic [IDX_W-1:0]  k;
    logic              k_last;
  } cls_item_t;

endpackage

@@ rtl/core/rldp_fifo.sv @@
// ----------------------------------------------------------------------------
// rldp_fifo
// Small register queue used between the front and back parts and on the
// result side.
// ----------------------------------------------------------------------------
module rldp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rldp_pkg::ITEM_Q_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [CW-1:0]    cnt_r;
  logic             wr_ok;
  logic             rd_ok;

  assign full = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr_ok = wr_en && !full;
  assign rd_ok = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_ok) begin
        wp_r <= (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
      end
      if (rd_ok) begin
        rp_r <= (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
      end
      case ({wr_ok, rd_ok})
        2'b10: cnt_r <= cnt_r + 1'b1;
        2'b01: cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

@@ rtl/core/rldp_front.sv @@
// ----------------------------------------------------------------------------
// rldp_front
// Accepts input items and classifies them against the print window.
// ----------------------------------------------------------------------------
module rldp_front #(
  parameter int LINE_BYTES_MAX = rldp_pkg::LINE_BYTES_MAX_DEF
) (
  input  rldp_pkg::cfg_t     cfg,
  input  logic               push,
  input  rldp_pkg::in_item_t in_data,
  input  logic               cls_full,
  output logic               full,
  output logic               cls_push,
  output rldp_pkg::cls_item_t cls_item
);

  localparam logic [rldp_pkg::LS_W:0] LINE_CAP = (rldp_pkg::LS_W + 1)'(LINE_BYTES_MAX);

  logic                          row_in;
  logic                          col_in;
  logic [rldp_pkg::COORD_W-1:0]  span;
  logic [rldp_pkg::COORD_W:0]    span_rnd;
  logic [rldp_pkg::LS_W-1:0]     ls_raw;
  logic [rldp_pkg::LS_W-1:0]     ls;
  logic [rldp_pkg::COORD_W-1:0]  first;
  logic [2:0]                    shift;
  logic                          col_ge;
  logic [rldp_pkg::COORD_W-1:0]  col_off;
  logic [rldp_pkg::COORD_W-1:0]  col_off_m1;
  logic [rldp_pkg::COORD_W-1:0]  ls_ext;
  logic [rldp_pkg::IDX_W-1:0]    k;
  logic                          k_ok;

  assign full = cls_full;
  assign cls_push = push && !cls_full;

  always_comb begin
    row_in = (in_data.row >= cfg.window_top) && (in_data.row < cfg.window_bottom) &&
             (cfg.window_right > cfg.window_left);
    col_in = (in_data.col >= cfg.window_left) && (in_data.col < cfg.window_right);

    span = cfg.window_right - cfg.window_left;
    span_rnd = {1'b0, span} + (rldp_pkg::COORD_W + 1)'(7);
    ls_raw = rldp_pkg::LS_W'(span_rnd >> 3);
    ls = ({1'b0, ls_raw} > LINE_CAP) ? rldp_pkg::LS_W'(LINE_CAP) : ls_raw;
    ls_ext = rldp_pkg::COORD_W'(ls);

    first = {3'b000, cfg.window_left[rldp_pkg::COORD_W-1:3]};
    shift = cfg.window_left[2:0];
    col_ge = (in_data.col >= first);
    col_off = in_data.col - first;
    col_off_m1 = col_off - 1'b1;

    if (shift == 3'd0) begin
      k_ok = col_ge && (col_off < ls_ext);
      k = col_off[rldp_pkg::IDX_W-1:0];
    end else begin
      k_ok = col_ge && (col_off != '0) && (col_off_m1 < ls_ext);
      k = col_off_m1[rldp_pkg::IDX_W-1:0];
    end

    if (in_data.cmd == rldp_pkg::CMD_LOAD) begin
      cls_item.kind = rldp_pkg::KIND_LOAD;
    end else if (row_in && !cfg.one_bit_mode && col_in) begin
      cls_item.kind = rldp_pkg::KIND_PIX;
    end else if (row_in && cfg.one_bit_mode) begin
      cls_item.kind = rldp_pkg::KIND_BYTE;
    end else begin
      cls_item.kind = rldp_pkg::KIND_PASS;
    end

    cls_item.tbl_addr = {in_data.row[rldp_pkg::SIDE_W-1:0], in_data.col[rldp_pkg::SIDE_W-1:0]};
    cls_item.value = in_data.value;
    cls_item.line_end = in_data.line_end;
    cls_item.edge_col = (in_data.col == (cfg.window_right - 1'b1));
    cls_item.k_ok = k_ok;
    cls_item.need_prev = (shift != 3'd0);
    cls_item.k = k;
    cls_item.k_last = ({1'b0, k} == (ls - 1'b1));
  end

endmodule

@@ rtl/core/rldp_back.sv @@
// ----------------------------------------------------------------------------
// rldp_back
// Threshold memory, dither compare, bit packing and byte realignment.
// ----------------------------------------------------------------------------
module rldp_back #(
  parameter int LINE_BYTES_MAX = rldp_pkg::LINE_BYTES_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rldp_pkg::cfg_t      cfg,
  input  logic                cls_valid,
  input  rldp_pkg::cls_item_t cls_item,
  output logic                cls_pop,
  input  logic                res_full,
  output logic                res_push,
  output rldp_pkg::out_item_t res_item
);

  localparam int CNT_W = $clog2(LINE_BYTES_MAX + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_BYTES_MAX);

  logic [7:0]          tbl_mem [rldp_pkg::TBL_DEPTH];
  logic [7:0]          thr_r;
  rldp_pkg::cls_item_t b_item_r;
  logic                b_valid_r;
  logic                b_go;

  logic [7:0]       pack_r;
  logic [7:0]       pack_nxt;
  logic [2:0]       bit_pos_r;
  logic [2:0]       bit_pos_nxt;
  logic [7:0]       prev_r;
  logic [7:0]       prev_nxt;
  logic             have_prev_r;
  logic             have_prev_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic [7:0]  level;
  logic [7:0]  pack_or;
  logic [15:0] pair;
  logic [7:0]  raw_byte;
  logic        emit;

  assign b_go = !res_full;
  assign cls_pop = cls_valid && (!b_valid_r || b_go);
  assign res_push = b_valid_r && b_go && emit;

  always_ff @(posedge clk) begin
    if (cls_pop) begin
      if (cls_item.kind == rldp_pkg::KIND_LOAD) begin
        tbl_mem[cls_item.tbl_addr] <= cls_item.value;
      end
      thr_r <= tbl_mem[cls_item.tbl_addr];
      b_item_r <= cls_item;
    end
  end

  always_comb begin
    pack_nxt = pack_r;
    bit_pos_nxt = bit_pos_r;
    prev_nxt = prev_r;
    have_prev_nxt = have_prev_r;
    cnt_nxt = cnt_r;
    emit = 1'b0;
    res_item = '0;

    level = cfg.black_space ? b_item_r.value : ~b_item_r.value;
    pack_or = pack_r | ((level >= thr_r) ? (rldp_pkg::DOT_MSB >> bit_pos_r) : 8'h00);
    pair = {prev_r, b_item_r.value} << cfg.window_left[2:0];
    raw_byte = b_item_r.need_prev ? pair[15:8] : b_item_r.value;

    case (b_item_r.kind)
      rldp_pkg::KIND_PIX: begin
        if ((bit_pos_r == rldp_pkg::LAST_BIT) || b_item_r.edge_col) begin
          if (cnt_r < CNT_MAX) begin
            emit = 1'b1;
            res_item.out_byte = pack_or;
            res_item.byte_index = rldp_pkg::IDX_W'(cnt_r);
            res_item.line_last = b_item_r.edge_col;
            cnt_nxt = cnt_r + 1'b1;
          end
          pack_nxt = '0;
          bit_pos_nxt = '0;
          if (b_item_r.edge_col) begin
            cnt_nxt = '0;
          end
        end else begin
          pack_nxt = pack_or;
          bit_pos_nxt = bit_pos_r + 1'b1;
        end
      end
      rldp_pkg::KIND_BYTE: begin
        if (b_item_r.k_ok && (!b_item_r.need_prev || have_prev_r)) begin
          emit = 1'b1;
          res_item.out_byte = raw_byte ^ {8{!cfg.black_space}};
          res_item.byte_index = b_item_r.k;
          res_item.line_last = b_item_r.k_last;
        end
        prev_nxt = b_item_r.value;
        have_prev_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    if ((b_item_r.kind != rldp_pkg::KIND_LOAD) && b_item_r.line_end) begin
      pack_nxt = '0;
      bit_pos_nxt = '0;
      prev_nxt = '0;
      have_prev_nxt = 1'b0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      pack_r <= '0;
      bit_pos_r <= '0;
      prev_r <= '0;
      have_prev_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cls_pop) begin
        b_valid_r <= 1'b1;
      end else if (b_go) begin
        b_valid_r <= 1'b0;
      end
      if (b_valid_r && b_go) begin
        pack_r <= pack_nxt;
        bit_pos_r <= bit_pos_nxt;
        prev_r <= prev_nxt;
        have_prev_r <= have_prev_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

@@ rtl/core/raster_line_dither_pack.sv @@
// ----------------------------------------------------------------------------
// raster_line_dither_pack
// Converts raster lines into packed one-bit printer lines inside a window.
//
// Items enter through push/full and results leave through empty/pop; both
// sides behave as queues. A transfer happens on an edge where push is high
// and full is low, or where pop is high and empty is low. Threshold loads
// and samples outside the window give no result; a sample gives at most one.
// The user must write configuration through the APB port only while the block
// is idle; the block does not enforce it. A sample is held in the back stage
// and its result in the result queue. One item is taken per cycle in steady
// state; the rate is set by the single pass through the threshold memory read
// and the pack stage. When pop stays low, the two-entry result queue fills,
// the pack stage holds, and the four-entry item queue raises full.
// Reset empties both queues, clears the line state and loads the register
// reset values. The threshold memory holds unknown data until it is loaded.
// ----------------------------------------------------------------------------
module raster_line_dither_pack #(
  parameter int LINE_BYTES_MAX = rldp_pkg::LINE_BYTES_MAX_DEF,
  parameter int ITEM_Q_DEPTH = rldp_pkg::ITEM_Q_DEPTH_DEF,
  parameter int RES_Q_DEPTH = rldp_pkg::RES_Q_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  rldp_pkg::in_item_t          in_data,
  output logic                        empty,
  input  logic                        pop,
  output rldp_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rldp_pkg::CFG_AW-1:0] paddr,
  input  logic [rldp_pkg::CFG_DW-1:0] pwdata,
  output logic [rldp_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  rldp_pkg::cfg_t      cfg_r;
  logic                cfg_wr;
  logic [2:0]          reg_idx;

  logic                cls_push;
  logic                cls_full;
  rldp_pkg::cls_item_t cls_wr_item;
  rldp_pkg::cls_item_t cls_rd_item;
  logic                cls_empty;
  logic                cls_pop;
  logic                res_push;
  logic                res_full;
  rldp_pkg::out_item_t res_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign reg_idx = paddr[rldp_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_left <= '0;
      cfg_r.window_right <= '0;
      cfg_r.window_top <= '0;
      cfg_r.window_bottom <= '0;
      cfg_r.one_bit_mode <= 1'b0;
      cfg_r.black_space <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rldp_pkg::REG_WINDOW_LEFT: cfg_r.window_left <= pwdata[rldp_pkg::COORD_W-1:0];
        rldp_pkg::REG_WINDOW_RIGHT: cfg_r.window_right <= pwdata[rldp_pkg::COORD_W-1:0];
        rldp_pkg::REG_WINDOW_TOP: cfg_r.window_top <= pwdata[rldp_pkg::COORD_W-1:0];
        rldp_pkg::REG_WINDOW_BOTTOM: cfg_r.window_bottom <= pwdata[rldp_pkg::COORD_W-1:0];
        rldp_pkg::REG_ONE_BIT_MODE: cfg_r.one_bit_mode <= pwdata[0];
        rldp_pkg::REG_BLACK_SPACE: cfg_r.black_space <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rldp_pkg::REG_WINDOW_LEFT: prdata = rldp_pkg::CFG_DW'(cfg_r.window_left);
      rldp_pkg::REG_WINDOW_RIGHT: prdata = rldp_pkg::CFG_DW'(cfg_r.window_right);
      rldp_pkg::REG_WINDOW_TOP: prdata = rldp_pkg::CFG_DW'(cfg_r.window_top);
      rldp_pkg::REG_WINDOW_BOTTOM: prdata = rldp_pkg::CFG_DW'(cfg_r.window_bottom);
      rldp_pkg::REG_ONE_BIT_MODE: prdata = rldp_pkg::CFG_DW'(cfg_r.one_bit_mode);
      rldp_pkg::REG_BLACK_SPACE: prdata = rldp_pkg::CFG_DW'(cfg_r.black_space);
      default: prdata = '0;
    endcase
  end

  rldp_front #(
    .LINE_BYTES_MAX(LINE_BYTES_MAX)
  ) u_front (
    .cfg     (cfg_r),
    .push    (push),
    .in_data (in_data),
    .cls_full(cls_full),
    .full    (full),
    .cls_push(cls_push),
    .cls_item(cls_wr_item)
  );

  rldp_fifo #(
    .WIDTH($bits(rldp_pkg::cls_item_t)),
    .DEPTH(ITEM_Q_DEPTH)
  ) u_item_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cls_push),
    .wr_data(cls_wr_item),
    .full   (cls_full),
    .rd_en  (cls_pop),
    .rd_data(cls_rd_item),
    .empty  (cls_empty)
  );

  rldp_back #(
    .LINE_BYTES_MAX(LINE_BYTES_MAX)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cls_valid(!cls_empty),
    .cls_item (cls_rd_item),
    .cls_pop  (cls_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  rldp_fifo #(
    .WIDTH($bits(rldp_pkg::out_item_t)),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res_item),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(out_data),
    .empty  (empty)
  );

  a_res_no_overflow: assert property (
    @(posedge clk) disable iff (!rst_n) !(res_push && res_full)
  ) else $error("Result pushed into a full result queue.");

  a_item_no_underflow: assert property (
    @(posedge clk) disable iff (!rst_n) !(cls_pop && cls_empty)
  ) else $error("Item popped from an empty item queue.");

  a_reset_clears: assert property (
    @(posedge clk) !rst_n |=> (empty && !full && cls_empty)
  ) else $error("Queues not empty after reset.");

endmodule
